FILE: sv/sttq_pkg.sv
// Package for the scheduled tick timer queue.
// Holds command and result codes and the payload types; no dependencies.
package sttq_pkg;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_CANCEL   = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;
    localparam logic [1:0] CMD_ADVANCE  = 2'd3;

    localparam logic [2:0] RK_SCHEDULED = 3'd0;
    localparam logic [2:0] RK_CANCELLED = 3'd1;
    localparam logic [2:0] RK_QUERY     = 3'd2;
    localparam logic [2:0] RK_DUE       = 3'd3;
    localparam logic [2:0] RK_IDLE      = 3'd4;

    localparam int unsigned MAX_RESULTS = 16;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] delay;
        logic [2:0]         tick_kind;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [2:0]         out_kind;
        logic               found;
        logic [4:0]         removed_count;
        logic               queue_full;
        logic               last;
    } result_item_t;

endpackage

FILE: sv/sttq_cmd_if.sv
// Valid/ready channel interface for command items.
// Depends on sttq_pkg for the payload type.
interface sttq_cmd_if;
    logic                valid;
    logic                ready;
    sttq_pkg::cmd_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/sttq_res_if.sv
// Valid/ready channel interface for result items.
// Depends on sttq_pkg for the payload type.
interface sttq_res_if;
    logic                   valid;
    logic                   ready;
    sttq_pkg::result_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/scheduled_tick_timer_queue.sv
// Scheduled tick timer queue: deferred ticks scanned one entry a cycle; uses sttq_pkg,
// sttq_cmd_if and sttq_res_if.
// After a command transfer, S_SCAN steps one shared compare through the table (QUEUE_DEPTH
// entries), S_EMIT registers the result and S_OUT holds it; each further due tick of an advance rescans.
// Not ready for a new command while busy, which includes while a result is stalled.
// Reset (rst_n, asynchronous) clears valid bits, the tick and order counters.
module scheduled_tick_timer_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sttq_cmd_if.sink     cmd_ch,
    sttq_res_if.source   res_ch
);
    import sttq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_EMIT = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [31:0] ex [QUEUE_DEPTH];
    logic [31:0] ey [QUEUE_DEPTH];
    logic [31:0] ez [QUEUE_DEPTH];
    logic [63:0] et [QUEUE_DEPTH];
    logic [2:0]  ek [QUEUE_DEPTH];
    logic [31:0] eo [QUEUE_DEPTH];

    logic [31:0] order_reg;
    logic [63:0] tick_reg;
    logic [2:0]  state_reg;
    cmd_item_t   cmd_reg;
    logic [IW-1:0] idx_reg;
    logic        hit_reg;
    logic [CW-1:0] cnt_reg;
    logic        best_ok_reg;
    logic [IW-1:0] best_reg;
    logic [63:0] best_t_reg;
    logic [31:0] best_age_reg;
    logic [4:0]  nemit_reg;
    logic        ovalid_reg;
    result_item_t odata_reg;

    logic match;
    logic due;
    logic [31:0] age;
    logic better;
    logic [63:0] dly;
    logic        store;
    result_item_t emit_res;

    assign cmd_ch.ready = (state_reg == S_IDLE);
    assign res_ch.valid = ovalid_reg;
    assign res_ch.data  = odata_reg;

    always_comb
    begin
        match = valid_reg[idx_reg] && ex[idx_reg] == cmd_reg.pos_x
             && ey[idx_reg] == cmd_reg.pos_y && ez[idx_reg] == cmd_reg.pos_z;
        due = valid_reg[idx_reg] && et[idx_reg] <= tick_reg;
        age = order_reg - eo[idx_reg];
        better = !best_ok_reg || et[idx_reg] < best_t_reg
              || (et[idx_reg] == best_t_reg && age > best_age_reg);
        if (cmd_reg.delay[15] || cmd_reg.delay == 16'sd0)
            dly = 64'd1;
        else
            dly = {48'd0, cmd_reg.delay};
        store = (state_reg == S_EMIT) && (cmd_reg.cmd == CMD_SCHEDULE) && hit_reg;
    end

    // result of the finished scan
    always_comb
    begin
        emit_res      = '0;
        emit_res.last = 1'b1;
        unique case (cmd_reg.cmd)
            CMD_SCHEDULE:
            begin
                emit_res.result_kind = RK_SCHEDULED;
                emit_res.queue_full  = !hit_reg;
            end
            CMD_CANCEL:
            begin
                emit_res.result_kind = RK_CANCELLED;
                if (cnt_reg > CW'(31))
                    emit_res.removed_count = 5'd31;
                else
                    emit_res.removed_count = 5'(cnt_reg);
            end
            CMD_QUERY:
            begin
                emit_res.result_kind = RK_QUERY;
                emit_res.found       = hit_reg;
            end
            CMD_ADVANCE:
            begin
                if (best_ok_reg)
                begin
                    emit_res.result_kind = RK_DUE;
                    emit_res.out_x       = ex[best_reg];
                    emit_res.out_y       = ey[best_reg];
                    emit_res.out_z       = ez[best_reg];
                    emit_res.out_kind    = ek[best_reg];
                    // final when no other entry was due or the result limit is reached
                    emit_res.last = (cnt_reg == CW'(1))
                                 || (nemit_reg == 5'(MAX_RESULTS - 1));
                end
                else
                    emit_res.result_kind = RK_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            ex[best_reg] <= cmd_reg.pos_x;
            ey[best_reg] <= cmd_reg.pos_y;
            ez[best_reg] <= cmd_reg.pos_z;
            et[best_reg] <= tick_reg + dly;
            ek[best_reg] <= cmd_reg.tick_kind;
            eo[best_reg] <= order_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            order_reg  <= '0;
            tick_reg   <= '0;
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            idx_reg    <= '0;
            hit_reg    <= 1'b0;
            cnt_reg    <= '0;
            best_ok_reg <= 1'b0;
            nemit_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_ch.valid)
                    begin
                        cmd_reg     <= cmd_ch.data;
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        cnt_reg     <= '0;
                        best_ok_reg <= 1'b0;
                        nemit_reg   <= '0;
                        if (cmd_ch.data.cmd == CMD_ADVANCE)
                            tick_reg <= tick_reg + 64'd1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // one entry per cycle through the shared compare
                    unique case (cmd_reg.cmd)
                        CMD_SCHEDULE:
                        begin
                            if (!valid_reg[idx_reg] && !hit_reg)
                            begin
                                hit_reg <= 1'b1;
                                best_reg <= idx_reg;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (match)
                            begin
                                valid_reg[idx_reg] <= 1'b0;
                                cnt_reg <= cnt_reg + CW'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (match)
                                hit_reg <= 1'b1;
                        end
                        CMD_ADVANCE:
                        begin
                            if (due)
                            begin
                                cnt_reg <= cnt_reg + CW'(1);
                                if (better)
                                begin
                                    best_ok_reg  <= 1'b1;
                                    best_reg     <= idx_reg;
                                    best_t_reg   <= et[idx_reg];
                                    best_age_reg <= age;
                                end
                            end
                        end
                        default: ;
                    endcase
                    if (idx_reg == LAST_IDX)
                        state_reg <= S_EMIT;
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                S_EMIT:
                begin
                    odata_reg  <= emit_res;
                    ovalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                    if (store)
                    begin
                        valid_reg[best_reg] <= 1'b1;
                        order_reg <= order_reg + 32'd1;
                    end
                    if (cmd_reg.cmd == CMD_ADVANCE && best_ok_reg)
                    begin
                        valid_reg[best_reg] <= 1'b0;
                        nemit_reg <= nemit_reg + 5'd1;
                    end
                end
                S_OUT:
                begin
                    if (res_ch.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        if (odata_reg.last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            // rescan for the next due tick
                            idx_reg     <= '0;
                            best_ok_reg <= 1'b0;
                            cnt_reg     <= '0;
                            state_reg   <= S_SCAN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/sv/scheduled_tick_timer_queue_tb.sv
// Testbench for the scheduled tick timer queue: directed table, then random commands.
// Results are checked against row values or a model of entry table and tick counter.
// Depends on sttq_pkg, sttq_cmd_if, sttq_res_if and scheduled_tick_timer_queue.
module scheduled_tick_timer_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sttq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_ITEMS  = 440;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        cmd_item_t    item;
        int           rep;
        bit           typed;
        result_item_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sttq_cmd_if cmd_ch ();
    sttq_res_if res_ch ();

    scheduled_tick_timer_queue #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    // model of the entry table
    bit          tq_valid [DEPTH];
    logic [31:0] tq_x     [DEPTH];
    logic [31:0] tq_y     [DEPTH];
    logic [31:0] tq_z     [DEPTH];
    logic [63:0] tq_tgt   [DEPTH];
    logic [2:0]  tq_kind  [DEPTH];
    logic [31:0] tq_ord   [DEPTH];
    logic [31:0] sched_count;
    logic [63:0] tick_now;

    result_item_t pending_results[$];
    stim_row_t    stim_rows[$];
    int           errors;
    int           items_sent;
    int           results_seen;
    int           dues_seen;
    int           drops_seen;
    bit           hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic cmd_item_t mk_cmd(logic [1:0] c, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z, logic [15:0] d, logic [2:0] k);
        cmd_item_t it;
        it.cmd       = c;
        it.pos_x     = x;
        it.pos_y     = y;
        it.pos_z     = z;
        it.delay     = d;
        it.tick_kind = k;
        return it;
    endfunction

    function automatic result_item_t mk_res(logic [2:0] rk, logic fnd, logic [4:0] rem,
                                            logic full);
        result_item_t r;
        r               = '0;
        r.result_kind   = rk;
        r.found         = fnd;
        r.removed_count = rem;
        r.queue_full    = full;
        r.last          = 1'b1;
        return r;
    endfunction

    function automatic void add_row(cmd_item_t it, int rep, bit typed, result_item_t r);
        stim_row_t s;
        s.item  = it;
        s.rep   = rep;
        s.typed = typed;
        s.res   = r;
        stim_rows.insert(stim_rows.size(), s);
    endfunction

    function automatic void expect_result(result_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void predict_results(input cmd_item_t it, output result_item_t r[$]);
        int           slot;
        int           best;
        int           cnt;
        logic [63:0]  d;
        logic [31:0]  age_i;
        logic [31:0]  age_b;
        result_item_t o;
        r = {};
        o = '0;
        unique case (it.cmd)
            CMD_SCHEDULE:
            begin
                slot = -1;
                for (int i = 0; i < DEPTH; i++)
                    if (!tq_valid[i] && slot < 0)
                        slot = i;
                d = (it.delay <= 0) ? 64'd1 : {48'd0, it.delay};
                o.result_kind = RK_SCHEDULED;
                if (slot < 0)
                    o.queue_full = 1'b1;
                else
                begin
                    tq_valid[slot] = 1'b1;
                    tq_x[slot]     = it.pos_x;
                    tq_y[slot]     = it.pos_y;
                    tq_z[slot]     = it.pos_z;
                    tq_tgt[slot]   = tick_now + d;
                    tq_kind[slot]  = it.tick_kind;
                    tq_ord[slot]   = sched_count;
                    sched_count    = sched_count + 32'd1;
                end
                r.insert(r.size(), o);
            end
            CMD_CANCEL, CMD_QUERY:
            begin
                cnt = 0;
                for (int i = 0; i < DEPTH; i++)
                    if (tq_valid[i] && tq_x[i] == it.pos_x && tq_y[i] == it.pos_y
                        && tq_z[i] == it.pos_z)
                    begin
                        cnt++;
                        if (it.cmd == CMD_CANCEL)
                            tq_valid[i] = 1'b0;
                    end
                if (it.cmd == CMD_CANCEL)
                begin
                    o.result_kind   = RK_CANCELLED;
                    o.removed_count = (cnt > 31) ? 5'd31 : 5'(cnt);
                end
                else
                begin
                    o.result_kind = RK_QUERY;
                    o.found       = (cnt != 0);
                end
                r.insert(r.size(), o);
            end
            CMD_ADVANCE:
            begin
                tick_now = tick_now + 64'd1;
                while (r.size() < MAX_RESULTS)
                begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!tq_valid[i] || tq_tgt[i] > tick_now)
                            continue;
                        if (best < 0 || tq_tgt[i] < tq_tgt[best])
                            best = i;
                        else if (tq_tgt[i] == tq_tgt[best])
                        begin
                            age_i = sched_count - tq_ord[i];
                            age_b = sched_count - tq_ord[best];
                            if (age_i > age_b)
                                best = i;
                        end
                    end
                    if (best < 0)
                        break;
                    tq_valid[best] = 1'b0;
                    o             = '0;
                    o.result_kind = RK_DUE;
                    o.out_x       = tq_x[best];
                    o.out_y       = tq_y[best];
                    o.out_z       = tq_z[best];
                    o.out_kind    = tq_kind[best];
                    r.insert(r.size(), o);
                end
                if (r.size() == 0)
                begin
                    o.result_kind = RK_IDLE;
                    r.insert(r.size(), o);
                end
            end
        endcase
        r[r.size() - 1].last = 1'b1;
    endfunction

    task automatic send_cmd(cmd_item_t it, bit typed, result_item_t typed_res);
        int           gap;
        result_item_t r[$];
        gap = $urandom_range(0, 10);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.data  <= it;
        cmd_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        predict_results(it, r);
        if (typed)
            expect_result(typed_res);
        else
            foreach (r[i])
                expect_result(r[i]);
        items_sent++;
    endtask

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected %0h, got %0h", name, e, a);
            errors++;
        end
    endtask

    // result side: random back-pressure, plus one long hold on request
    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                gap          = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_item_t e;
        result_item_t a;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            a = res_ch.data;
            results_seen++;
            if (a.result_kind == RK_DUE)
                dues_seen++;
            if (a.queue_full)
                drops_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result_kind %0d arrived with nothing expected", a.result_kind);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("result_kind", 32'(e.result_kind), 32'(a.result_kind));
                check_field("out_x", e.out_x, a.out_x);
                check_field("out_y", e.out_y, a.out_y);
                check_field("out_z", e.out_z, a.out_z);
                check_field("out_kind", 32'(e.out_kind), 32'(a.out_kind));
                check_field("found", 32'(e.found), 32'(a.found));
                check_field("removed_count", 32'(e.removed_count), 32'(a.removed_count));
                check_field("queue_full", 32'(e.queue_full), 32'(a.queue_full));
                check_field("last", 32'(e.last), 32'(a.last));
            end
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [31:0]  pool_x [4];
        logic [31:0]  pool_y [4];
        logic [31:0]  pool_z [4];
        logic [31:0]  x;
        logic [31:0]  y;
        logic [31:0]  z;
        logic [15:0]  d;
        logic [1:0]   c;
        int           pick;
        int           waited;
        result_item_t none;

        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        rst_n        = 1'b0;
        errors       = 0;
        items_sent   = 0;
        results_seen = 0;
        dues_seen    = 0;
        drops_seen   = 0;
        hold_request = 1'b0;
        sched_count  = '0;
        tick_now     = '0;
        foreach (tq_valid[i])
            tq_valid[i] = 1'b0;
        none = '0;

        // reset state, extremes, drop on full table
        add_row(mk_cmd(CMD_ADVANCE, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b1,
                mk_res(RK_IDLE, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_QUERY, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b1,
                mk_res(RK_QUERY, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_CANCEL, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b1,
                mk_res(RK_CANCELLED, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_SCHEDULE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0000, 3'd7),
                1, 1'b1, mk_res(RK_SCHEDULED, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_SCHEDULE, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 3'd0),
                1, 1'b1, mk_res(RK_SCHEDULED, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_SCHEDULE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 3'd3),
                1, 1'b1, mk_res(RK_SCHEDULED, 1'b0, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd0, 3'd0),
                1, 1'b1, mk_res(RK_QUERY, 1'b1, 5'd0, 1'b0));
        add_row(mk_cmd(CMD_ADVANCE, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b0, none);
        add_row(mk_cmd(CMD_CANCEL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'd0, 3'd0),
                1, 1'b1, mk_res(RK_CANCELLED, 1'b0, 5'd1, 1'b0));
        add_row(mk_cmd(CMD_SCHEDULE, 32'd5, 32'd5, 32'd5, 16'd3, 3'd5), 8, 1'b0, none);
        add_row(mk_cmd(CMD_SCHEDULE, 32'd6, 32'd6, 32'd6, 16'd1, 3'd2), 8, 1'b0, none);
        add_row(mk_cmd(CMD_SCHEDULE, 32'd9, 32'd9, 32'd9, 16'd1, 3'd1), 1, 1'b1,
                mk_res(RK_SCHEDULED, 1'b0, 5'd0, 1'b1));
        add_row(mk_cmd(CMD_CANCEL, 32'd5, 32'd5, 32'd5, 16'd0, 3'd0), 1, 1'b1,
                mk_res(RK_CANCELLED, 1'b0, 5'd8, 1'b0));
        add_row(mk_cmd(CMD_ADVANCE, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b0, none);
        add_row(mk_cmd(CMD_ADVANCE, 32'd0, 32'd0, 32'd0, 16'd0, 3'd0), 1, 1'b1,
                mk_res(RK_IDLE, 1'b0, 5'd0, 1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            repeat (stim_rows[i].rep)
                send_cmd(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);

        pool_x = '{32'd0, 32'hffffffff, 32'h7fffffff, $urandom};
        pool_y = '{32'd0, 32'hffffffff, 32'h80000000, $urandom};
        pool_z = '{32'd0, 32'hffffffff, 32'd1, $urandom};

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 150)
                hold_request = 1'b1;
            // let the queue drain completely once
            if (n == 300)
            begin
                cmd_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            c = (pick < 40) ? CMD_SCHEDULE : (pick < 75) ? CMD_ADVANCE :
                (pick < 85) ? CMD_CANCEL : CMD_QUERY;
            pick = $urandom_range(0, 3);
            x = pool_x[pick];
            y = pool_y[pick];
            z = pool_z[pick];
            pick = $urandom_range(0, 99);
            if (pick < 70)
                d = 16'($urandom_range(1, 6));
            else if (pick < 80)
                d = ($urandom_range(0, 1) == 0) ? 16'd0 : {1'b1, 15'($urandom)};
            else
                d = 16'($urandom);
            // fresh positions only with short delays, so no entry is stranded
            if ($urandom_range(0, 3) == 0 && (d[15] || d <= 16'd6))
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            send_cmd(mk_cmd(c, x, y, z, d, 3'($urandom)), 1'b0, none);
        end
        cmd_ch.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("covered %0d commands, %0d results, %0d due ticks, %0d dropped schedules",
                 items_sent, results_seen, dues_seen, drops_seen);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
sv/sttq_pkg.sv
sv/sttq_cmd_if.sv
sv/sttq_res_if.sv
sv/scheduled_tick_timer_queue.sv
tb/sv/scheduled_tick_timer_queue_tb.sv
